### src/assert_macros.svh
// Assertion macros shared by the RTL of the search block.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock edge, disabled in reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
// Assert that a signal carries no unknown bits out of reset.
`define ASSERT_KNOWN(lbl, clk, rstn, sig) \
  `ASSERT_CLK(lbl, clk, rstn, !$isunknown(sig))
`endif

### src/dfst_pkg.sv
// Package for the depth-first search block: sizes, codes and shared types.
// No dependencies.
package dfst_pkg;
  localparam int MaxVertices = 16;
  localparam int MaxEdges    = 64;
  localparam int VW = 4;   // vertex index width
  localparam int TW = 6;   // time field width

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_REPORT = 3'd3,
    ST_CLEAR  = 3'd4
  } status_e;
endpackage

### src/dfst_edge_mem.sv
// Edge store memory: target and next pointer per edge, one write port and
// one registered read port. Depends on dfst_pkg.
module dfst_edge_mem #(
  parameter int MaxEdges = dfst_pkg::MaxEdges,
  parameter int EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [EW-1:0]           waddr_i,
  input  logic [dfst_pkg::VW-1:0] wtarget_i,
  input  logic                    wnext_valid_i,
  input  logic [EW-1:0]           wnext_i,
  input  logic [EW-1:0]           raddr_i,
  output logic [dfst_pkg::VW-1:0] rtarget_o,
  output logic                    rnext_valid_o,
  output logic [EW-1:0]           rnext_o
);
  logic [dfst_pkg::VW+EW:0] mem [MaxEdges];
  logic [dfst_pkg::VW+EW:0] rd_q;

  // Write one entry and read one entry; the read data is registered
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= {wtarget_i, wnext_valid_i, wnext_i};
    rd_q <= mem[raddr_i];
  end

  assign rtarget_o     = rd_q[dfst_pkg::VW+EW:EW+1];
  assign rnext_valid_o = rd_q[EW];
  assign rnext_o       = rd_q[EW-1:0];
endmodule

### src/depth_first_search_timestamps.sv
// Depth-first search with discovery/finish timestamps. Add-edge and clear
// items give one result each; an undefined operation gives none. A run item
// holds the input while a sequencer walks the graph: each edge visit steps
// through stack top, memory read and edge update, the read step set by the
// single registered read port of the edge memory; each vertex is scanned as a
// root and later finished, each search tree returns to the root scan, then
// each vertex is reported in two steps (load, advance), held while the output
// stalls. Depends on dfst_pkg, dfst_edge_mem and
// assert_macros.svh.
`include "assert_macros.svh"
module depth_first_search_timestamps #(
  parameter int MaxEdges    = dfst_pkg::MaxEdges
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] source_vertex, [7:4] target_vertex
  input  logic [7:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] vertex_id, [9:4] discovery_time, [15:10] finish_time,
  // [19:16] parent_vertex, [20] has_parent
  output logic [23:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  localparam int MaxVertices = dfst_pkg::MaxVertices;
  localparam int VW = dfst_pkg::VW;
  localparam int TW = dfst_pkg::TW;
  localparam int EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int CW = $clog2(MaxEdges+1);
  localparam int SW = $clog2(MaxVertices+1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ROOT   = 7'b0000010,
    S_TOP    = 7'b0000100,
    S_WAIT   = 7'b0001000,
    S_EDGE   = 7'b0010000,
    S_REPORT = 7'b0100000,
    S_SEND   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] vcnt_q;
  logic [SW-1:0] n_act;
  logic [EW-1:0] head_q [MaxVertices];
  logic [MaxVertices-1:0] head_v_q;
  logic [CW-1:0] stored_q;
  logic [MaxVertices-1:0] gray_q, black_q, pvalid_q;
  logic [VW-1:0] par_q [MaxVertices];
  logic [TW-1:0] disc_q [MaxVertices];
  logic [TW-1:0] fin_q [MaxVertices];
  logic [VW-1:0] stk_v_q [MaxVertices];
  logic [MaxVertices-1:0] stk_cv_q;
  logic [EW-1:0] stk_c_q [MaxVertices];
  logic [SW-1:0] sp_q;
  logic [TW-1:0] tick_q;
  logic [SW-1:0] root_q;
  logic [VW-1:0] rep_q;
  logic          out_v_q, out_last_q;
  logic [23:0]   out_q;
  logic [2:0]    out_st_q;

  logic [1:0] op;
  logic [VW-1:0] src, tgt;
  logic in_fire, out_free;
  logic [EW-1:0] raddr;
  logic [VW-1:0] rtgt;
  logic rnv;
  logic [EW-1:0] rnext;
  logic [SW-1:0] top;
  logic [VW-1:0] top_v;
  logic mem_we;
  logic [VW-1:0] root_v;

  assign op  = s_axis_tuser;
  assign src = s_axis_tdata[3:0];
  assign tgt = s_axis_tdata[7:4];
  assign n_act = (vcnt_q == 5'd0) ? SW'(1) :
                 ({1'b0, vcnt_q} > 6'(MaxVertices)) ? SW'(MaxVertices) : SW'(vcnt_q);
  assign out_free = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign top = sp_q - SW'(1);
  assign top_v = stk_v_q[top[VW-1:0]];
  assign root_v = root_q[VW-1:0];
  assign raddr = stk_c_q[top[VW-1:0]];
  assign mem_we = in_fire && (op == dfst_pkg::OP_ADD) &&
                  ({1'b0, src} < 5'(n_act)) && ({1'b0, tgt} < 5'(n_act)) &&
                  (stored_q < CW'(MaxEdges));

  dfst_edge_mem #(.MaxEdges(MaxEdges), .EW(EW)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(stored_q[EW-1:0]), .wtarget_i(tgt),
    .wnext_valid_i(head_v_q[src]), .wnext_i(head_q[src]),
    .raddr_i(raddr), .rtarget_o(rtgt), .rnext_valid_o(rnv), .rnext_o(rnext));

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire && op == dfst_pkg::OP_RUN) state_d = S_ROOT;
      S_ROOT:   if (root_q >= n_act) state_d = S_REPORT;
                else if (!gray_q[root_v] && !black_q[root_v]) state_d = S_TOP;
      S_TOP:    if (sp_q == '0) state_d = S_ROOT;
                else if (stk_cv_q[top[VW-1:0]]) state_d = S_WAIT;
      S_WAIT:   state_d = S_EDGE;
      S_EDGE:   state_d = S_TOP;
      S_REPORT: if (out_free) state_d = S_SEND;
      S_SEND:   state_d = (rep_q == VW'(n_act - SW'(1))) ? S_IDLE : S_REPORT;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q <= 5'd16;
      head_v_q <= '0;
      stored_q <= '0;
      gray_q <= '0; black_q <= '0; pvalid_q <= '0;
      stk_cv_q <= '0;
      sp_q <= '0; tick_q <= '0; root_q <= '0; rep_q <= '0;
      out_v_q <= 1'b0; out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      // Raise valid on a new result, drop it after the transfer
      if ((in_fire && (op == dfst_pkg::OP_ADD || op == dfst_pkg::OP_CLEAR)) ||
          (state_q == S_REPORT && out_free)) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      // Single-result items and run setup
      if (in_fire) begin
        unique case (op)
          dfst_pkg::OP_ADD: begin
            out_last_q <= 1'b1;
            if (mem_we) begin
              head_v_q[src] <= 1'b1;
              stored_q <= stored_q + CW'(1);
            end
          end
          dfst_pkg::OP_CLEAR: begin
            out_last_q <= 1'b1;
            head_v_q <= '0; stored_q <= '0;
          end
          dfst_pkg::OP_RUN: begin
            gray_q <= '0; black_q <= '0; pvalid_q <= '0;
            tick_q <= '0; sp_q <= '0; root_q <= '0; rep_q <= '0;
          end
          default: ;
        endcase
      end
      // Walk
      if (state_q == S_ROOT) begin
        if (root_q < n_act) begin
          root_q <= root_q + SW'(1);
          if (!gray_q[root_v] && !black_q[root_v]) begin
            tick_q <= tick_q + TW'(1);
            gray_q[root_v] <= 1'b1;
            stk_cv_q[0] <= head_v_q[root_v];
            sp_q <= SW'(1);
          end
        end
      end
      if (state_q == S_TOP && sp_q != '0 && !stk_cv_q[top[VW-1:0]]) begin
        sp_q <= top;
        tick_q <= tick_q + TW'(1);
        black_q[top_v] <= 1'b1;
        gray_q[top_v] <= 1'b0;
      end
      if (state_q == S_EDGE) begin
        stk_cv_q[top[VW-1:0]] <= rnv;
        if ({1'b0, rtgt} < 5'(n_act) && !gray_q[rtgt] && !black_q[rtgt]) begin
          pvalid_q[rtgt] <= 1'b1;
          tick_q <= tick_q + TW'(1);
          gray_q[rtgt] <= 1'b1;
          if (sp_q < SW'(MaxVertices)) begin
            stk_cv_q[sp_q[VW-1:0]] <= head_v_q[rtgt];
            sp_q <= sp_q + SW'(1);
          end
        end
      end
      if (state_q == S_REPORT && out_free) begin
        out_last_q <= (rep_q == VW'(n_act - SW'(1)));
      end
      if (state_q == S_SEND) rep_q <= rep_q + VW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mem_we) head_q[src] <= stored_q[EW-1:0];
    if (in_fire) begin
      unique case (op)
        dfst_pkg::OP_ADD: begin
          out_q <= '0;
          out_st_q <= mem_we ? dfst_pkg::ST_OK :
                      (({1'b0, src} >= 5'(n_act)) || ({1'b0, tgt} >= 5'(n_act)))
                      ? dfst_pkg::ST_RANGE : dfst_pkg::ST_FULL;
        end
        dfst_pkg::OP_CLEAR: begin
          out_q <= '0;
          out_st_q <= dfst_pkg::ST_CLEAR;
        end
        default: ;
      endcase
    end
    if (state_q == S_ROOT && root_q < n_act && !gray_q[root_v] && !black_q[root_v]) begin
      disc_q[root_v] <= tick_q + TW'(1);
      stk_v_q[0] <= root_v;
      stk_c_q[0] <= head_q[root_v];
    end
    if (state_q == S_TOP && sp_q != '0 && !stk_cv_q[top[VW-1:0]])
      fin_q[top_v] <= tick_q + TW'(1);
    if (state_q == S_EDGE) begin
      stk_c_q[top[VW-1:0]] <= rnext;
      if ({1'b0, rtgt} < 5'(n_act) && !gray_q[rtgt] && !black_q[rtgt]) begin
        par_q[rtgt] <= top_v;
        disc_q[rtgt] <= tick_q + TW'(1);
        if (sp_q < SW'(MaxVertices)) begin
          stk_v_q[sp_q[VW-1:0]] <= rtgt;
          stk_c_q[sp_q[VW-1:0]] <= head_q[rtgt];
        end
      end
    end
    if (state_q == S_REPORT && out_free) begin
      out_st_q <= dfst_pkg::ST_REPORT;
      out_q <= {3'd0, pvalid_q[rep_q], pvalid_q[rep_q] ? par_q[rep_q] : VW'(0),
                fin_q[rep_q], disc_q[rep_q], rep_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  `ASSERT_CLK(a_no_in_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !s_axis_tready)
  `ASSERT_CLK(a_sp_bound, clk_i, rst_ni, sp_q <= SW'(MaxVertices))
  `ASSERT_CLK(a_gray_black, clk_i, rst_ni, (gray_q & black_q) == '0)
  `ASSERT_KNOWN(a_tvalid_known, clk_i, rst_ni, m_axis_tvalid)
endmodule
